// ===== hw/rtl/watchdog_with_output_selftest_macros.svh =====
// assertion macros for the watchdog with output self-test
// used by the port checker; expects clk and rst_n in the enclosing scope
`ifndef WATCHDOG_WITH_OUTPUT_SELFTEST_MACROS_SVH
`define WATCHDOG_WITH_OUTPUT_SELFTEST_MACROS_SVH

// property checked outside reset
`define WDST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define WDST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/wdst_pkg.sv =====
// shared types and constants of the watchdog with output self-test
// no dependencies
package wdst_pkg;

  localparam int OPCODE_W = 2;
  localparam int FLAGS_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W    = 16;
  localparam int STABLE_W = 8;
  localparam int REPEAT_W = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 2'd0,
    OP_KICK    = 2'd1,
    OP_REQUEST = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    WD_INIT  = 2'd0,
    WD_OK    = 2'd1,
    WD_ERROR = 2'd2
  } wd_state_t;

  typedef enum logic [2:0] {
    TS_INITIAL    = 3'd0,
    TS_EXPECT_ON  = 3'd1,
    TS_EXPECT_OFF = 3'd2,
    TS_PASSED     = 3'd3,
    TS_FAILED     = 3'd4
  } test_state_t;

  typedef enum logic [1:0] {
    POLL_WAIT    = 2'd0,
    POLL_TIMEOUT = 2'd1,
    POLL_OK      = 2'd2
  } poll_res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 3'd0,
    CFG_LOCK_TICKS    = 3'd1,
    CFG_TIMEOUT_TICKS = 3'd2,
    CFG_REPEAT_TICKS  = 3'd3,
    CFG_STABLE_TICKS  = 3'd4
  } cfg_reg_t;

  // error flag bit positions
  localparam int FLG_INITIAL = 0;
  localparam int FLG_ON      = 1;
  localparam int FLG_OFF     = 2;
  localparam int FLG_MISSED  = 3;
  localparam int FLG_CLEARED = 4;
  localparam int FLG_NOTTRIG = 5;
  localparam int FLG_STOPPED = 6;

  // register reset values (10 ms tick)
  localparam logic [CNT_W-1:0]    TRIGGER_TICKS_RST = 16'd6000;
  localparam logic [CNT_W-1:0]    LOCK_TICKS_RST    = 16'd3000;
  localparam logic [CNT_W-1:0]    TIMEOUT_TICKS_RST = 16'd10000;
  localparam logic [REPEAT_W-1:0] REPEAT_TICKS_RST  = 32'd360000000;
  localparam logic [STABLE_W-1:0] STABLE_TICKS_RST  = 8'd5;

endpackage

// ===== hw/rtl/wdst_in_if.sv =====
// input channel of the watchdog: valid/ready plus command fields
// depends on wdst_pkg for field widths
interface wdst_in_if;
  logic                          valid;
  logic                          ready;
  logic [wdst_pkg::OPCODE_W-1:0] opcode;
  logic                          readback;
  logic                          kick_nonzero;

  modport source (output valid, output opcode, output readback, output kick_nonzero,
                  input ready);
  modport sink   (input valid, input opcode, input readback, input kick_nonzero,
                  output ready);
endinterface

// ===== hw/rtl/wdst_out_if.sv =====
// result channel of the watchdog: valid/ready plus status fields
// depends on wdst_pkg for field widths
interface wdst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         relay_on;
  logic                         running;
  logic [1:0]                   wd_mode;
  logic                         reset_locked;
  logic [wdst_pkg::FLAGS_W-1:0] error_flags;
  logic                         test_passed;
  logic                         request_accepted;

  modport source (output valid, output relay_on, output running, output wd_mode,
                  output reset_locked, output error_flags, output test_passed,
                  output request_accepted, input ready);
  modport sink   (input valid, input relay_on, input running, input wd_mode,
                  input reset_locked, input error_flags, input test_passed,
                  input request_accepted, output ready);
endinterface

// ===== hw/rtl/watchdog_with_output_selftest.sv =====
// watchdog with relay drive and relay self-test; a beat goes from the input register to the result register
// throughput one beat per cycle while out_ch.ready does not stall the result stage: input register,
// combinational state update (counters and self-test fsm), result register
// rst_n is synchronous, active low: clears the valid bits of both stages, state and error flags,
// and loads the configuration registers with their defaults
module watchdog_with_output_selftest (
  input  logic                              clk,
  input  logic                              rst_n,
  wdst_in_if.sink                           in_ch,
  wdst_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [wdst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wdst_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wdst_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]    trigger_ticks_r, lock_ticks_r, timeout_ticks_r;
  logic [REPEAT_W-1:0] repeat_ticks_r;
  logic [STABLE_W-1:0] stable_ticks_r;

  // input stage
  logic                in_valid_r;
  logic [OPCODE_W-1:0] in_opcode_r;
  logic                in_readback_r;
  logic                in_kick_r;

  // watchdog and self-test state
  logic [CNT_W-1:0]    wd_count_r, wd_count_nxt;
  wd_state_t           wd_state_r, wd_state_nxt;
  logic [CNT_W-1:0]    lock_count_r, lock_count_nxt;
  test_state_t         test_state_r, test_state_nxt;
  logic                test_pending_r, test_pending_nxt;
  logic [STABLE_W-1:0] stable_count_r, stable_count_nxt;
  logic [CNT_W-1:0]    timeout_count_r, timeout_count_nxt;
  logic [REPEAT_W-1:0] repeat_rem_r, repeat_rem_nxt;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt;

  // result stage
  logic               out_valid_r;
  logic               relay_r, running_r, locked_r, passed_r, accepted_r;
  logic [1:0]         mode_r;
  logic [FLAGS_W-1:0] out_flags_r;

  logic advance;
  logic relay_nxt, passed_nxt, accepted_nxt;

  // readback poll of the current test step
  logic [STABLE_W-1:0] stable_min1, sc0, poll_sc;
  logic [CNT_W-1:0]    timeout_min1, tc0, tc_dec, poll_tc;
  logic                poll_expect;
  poll_res_t           poll_res;

  // move the held beat to the result stage when that is free or being drained
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.relay_on         = relay_r;
  assign out_ch.running          = running_r;
  assign out_ch.wd_mode          = mode_r;
  assign out_ch.reset_locked     = locked_r;
  assign out_ch.error_flags      = out_flags_r;
  assign out_ch.test_passed      = passed_r;
  assign out_ch.request_accepted = accepted_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      lock_ticks_r    <= LOCK_TICKS_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      repeat_ticks_r  <= REPEAT_TICKS_RST;
      stable_ticks_r  <= STABLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_data[CNT_W-1:0];
        CFG_LOCK_TICKS:    lock_ticks_r    <= cfg_data[CNT_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[CNT_W-1:0];
        CFG_REPEAT_TICKS:  repeat_ticks_r  <= cfg_data[REPEAT_W-1:0];
        CFG_STABLE_TICKS:  stable_ticks_r  <= cfg_data[STABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // poll: a zero stable count means the step starts fresh and reloads both counters
  always_comb begin
    stable_min1  = (stable_ticks_r == '0) ? STABLE_W'(1) : stable_ticks_r;
    timeout_min1 = (timeout_ticks_r == '0) ? CNT_W'(1) : timeout_ticks_r;
    sc0          = (stable_count_r == '0) ? stable_min1 : stable_count_r;
    tc0          = (stable_count_r == '0) ? timeout_min1 : timeout_count_r;
    tc_dec       = (tc0 != '0) ? tc0 - CNT_W'(1) : tc0;
    poll_expect  = (test_state_r == TS_EXPECT_ON);
    if (poll_expect == in_readback_r) begin
      // matching level: count toward a stable pass
      poll_sc  = sc0 - STABLE_W'(1);
      poll_tc  = tc0;
      poll_res = (sc0 == STABLE_W'(1)) ? POLL_OK : POLL_WAIT;
    end else if (tc_dec == '0) begin
      // mismatch used up the timeout
      poll_sc  = '0;
      poll_tc  = tc_dec;
      poll_res = POLL_TIMEOUT;
    end else begin
      // mismatch restarts the stable window
      poll_sc  = stable_min1;
      poll_tc  = tc_dec;
      poll_res = POLL_WAIT;
    end
  end

  // state update for the beat in the input stage
  always_comb begin
    logic approval;
    logic kill;
    wd_count_nxt      = wd_count_r;
    wd_state_nxt      = wd_state_r;
    lock_count_nxt    = lock_count_r;
    test_state_nxt    = test_state_r;
    test_pending_nxt  = test_pending_r;
    stable_count_nxt  = stable_count_r;
    timeout_count_nxt = timeout_count_r;
    repeat_rem_nxt    = repeat_rem_r;
    flags_nxt         = flags_r;
    relay_nxt         = 1'b0;
    passed_nxt        = 1'b0;
    accepted_nxt      = 1'b0;
    approval          = 1'b0;
    kill              = 1'b0;

    case (in_opcode_r)
      OP_TICK: begin
        // self-test steps only while the watchdog runs
        if (wd_count_r != '0) begin
          case (test_state_r)
            TS_INITIAL, TS_EXPECT_OFF: begin
              stable_count_nxt  = poll_sc;
              timeout_count_nxt = poll_tc;
              if (poll_res == POLL_TIMEOUT) begin
                if (test_state_r == TS_INITIAL) flags_nxt[FLG_INITIAL] = 1'b1;
                else flags_nxt[FLG_OFF] = 1'b1;
                test_state_nxt = TS_FAILED;
              end else if (poll_res == POLL_OK) begin
                approval       = 1'b1;
                repeat_rem_nxt = repeat_ticks_r;
                test_state_nxt = TS_PASSED;
                passed_nxt     = 1'b1;
              end
            end
            TS_EXPECT_ON: begin
              approval          = 1'b1;
              stable_count_nxt  = poll_sc;
              timeout_count_nxt = poll_tc;
              if (poll_res == POLL_TIMEOUT) begin
                flags_nxt[FLG_ON] = 1'b1;
                test_state_nxt    = TS_FAILED;
              end else if (poll_res == POLL_OK) begin
                test_state_nxt = TS_EXPECT_OFF;
              end
            end
            TS_PASSED: begin
              approval = 1'b1;
              if (test_pending_r) begin
                test_pending_nxt = 1'b0;
                test_state_nxt   = TS_EXPECT_ON;
              end else if (repeat_rem_r != '0) begin
                repeat_rem_nxt = repeat_rem_r - REPEAT_W'(1);
              end else begin
                flags_nxt[FLG_MISSED] = 1'b1;
                test_state_nxt        = TS_FAILED;
              end
            end
            default: kill = 1'b1; // failed test holds the error state
          endcase
        end
        // watchdog countdown
        if (kill) begin
          wd_count_nxt = '0;
          wd_state_nxt = WD_ERROR;
        end else if (wd_count_r != '0) begin
          wd_count_nxt = wd_count_r - CNT_W'(1);
          if (wd_count_r == CNT_W'(1)) begin
            flags_nxt[FLG_NOTTRIG] = 1'b1;
            wd_state_nxt           = WD_ERROR;
          end
        end else if (wd_state_r == WD_OK) begin
          flags_nxt[FLG_STOPPED] = 1'b1;
          wd_state_nxt           = WD_ERROR;
        end
        // lock counter falls once on every tick that ends in error, until it reaches zero
        if (wd_state_nxt == WD_ERROR && lock_count_r != '0)
          lock_count_nxt = lock_count_r - CNT_W'(1);
        relay_nxt = approval && (wd_count_nxt != '0);
      end
      OP_KICK: begin
        if (wd_state_r != WD_ERROR) begin
          if (in_kick_r) begin
            wd_count_nxt   = trigger_ticks_r;
            lock_count_nxt = lock_ticks_r;
            wd_state_nxt   = WD_OK;
          end else if (wd_state_r != WD_INIT) begin
            // clear command forces error
            wd_count_nxt           = '0;
            wd_state_nxt           = WD_ERROR;
            flags_nxt[FLG_CLEARED] = 1'b1;
            if (lock_count_r != '0) lock_count_nxt = lock_count_r - CNT_W'(1);
          end
        end
      end
      OP_REQUEST: begin
        if (test_state_r == TS_PASSED) begin
          test_pending_nxt = 1'b1;
          accepted_nxt     = 1'b1;
        end
      end
      default: ; // unused opcode leaves state alone
    endcase
  end

  // input stage and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      wd_count_r      <= '0;
      wd_state_r      <= WD_INIT;
      lock_count_r    <= '0;
      test_state_r    <= TS_INITIAL;
      test_pending_r  <= 1'b0;
      stable_count_r  <= '0;
      timeout_count_r <= '0;
      repeat_rem_r    <= '0;
      flags_r         <= '0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (advance) begin
        wd_count_r      <= wd_count_nxt;
        wd_state_r      <= wd_state_nxt;
        lock_count_r    <= lock_count_nxt;
        test_state_r    <= test_state_nxt;
        test_pending_r  <= test_pending_nxt;
        stable_count_r  <= stable_count_nxt;
        timeout_count_r <= timeout_count_nxt;
        repeat_rem_r    <= repeat_rem_nxt;
        flags_r         <= flags_nxt;
      end
    end
  end

  // input payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_opcode_r   <= in_ch.opcode;
      in_readback_r <= in_ch.readback;
      in_kick_r     <= in_ch.kick_nonzero;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_r     <= relay_nxt;
      running_r   <= (wd_count_nxt != '0);
      mode_r      <= wd_state_nxt;
      locked_r    <= (lock_count_nxt != '0);
      out_flags_r <= flags_nxt;
      passed_r    <= passed_nxt;
      accepted_r  <= accepted_nxt;
    end
  end

endmodule

// ===== hw/rtl/wdst_checker.sv =====
// port-level checks of the watchdog result channel, bound to the top level
// depends on wdst_pkg and the assertion macro header
`include "watchdog_with_output_selftest_macros.svh"

module wdst_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         relay_on,
  input logic                         running,
  input logic [1:0]                   wd_mode,
  input logic [wdst_pkg::FLAGS_W-1:0] error_flags
);
  import wdst_pkg::*;

  // flags of the previous cycle, to see that none is ever dropped
  logic [FLAGS_W-1:0] prev_flags_r;
  logic               flags_kept;

  always_ff @(posedge clk) begin
    prev_flags_r <= error_flags;
  end

  assign flags_kept = ((error_flags & prev_flags_r) == prev_flags_r);

  `WDST_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
  `WDST_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `WDST_ASSERT(a_relay_running, out_valid && relay_on |-> running, "relay on while stopped")
  `WDST_ASSERT(a_running_ok, out_valid && running |-> wd_mode == WD_OK, "running outside ok")
  `WDST_ASSERT(a_flags_sticky, out_valid && out_ready ##1 out_valid |-> flags_kept, "flag dropped")

endmodule

bind watchdog_with_output_selftest wdst_checker u_wdst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .relay_on    (out_ch.relay_on),
  .running     (out_ch.running),
  .wd_mode     (out_ch.wd_mode),
  .error_flags (out_ch.error_flags)
);
